### sv/csim_pkg.sv
package csim_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int MAX_LEN     = 4096;
	localparam int SUM_W       = 60;
	localparam int PROD_W      = 2 * SAMPLE_BITS;
	localparam int CNT_W       = $clog2(MAX_LEN + 1);
	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W      = $clog2(QDEPTH + 1);
	localparam int LIMB_W      = SUM_W / 2;
	localparam int WIDE_W      = 2 * SUM_W;
	localparam int QUO_W       = 31;
	localparam int SIM_W       = 16;
	localparam int ADDR_W      = 3;

	localparam logic [0:0] REG_THRESHOLD = 1'b0;
	localparam logic signed [SIM_W-1:0] THR_RESET = 16'sd32604;
	localparam logic [SIM_W-2:0] SIM_MAX = '1;

	typedef struct packed {
		logic [SUM_W-1:0] dot;
		logic [SUM_W-1:0] norm_a;
		logic [SUM_W-1:0] norm_b;
		logic             inval;
	} job_t;

endpackage

### sv/csim_front.sv
module csim_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              take,
	input  logic signed [23:0]                sample_a,
	input  logic signed [23:0]                sample_b,
	input  logic                              last_item,
	output logic                              last_in_flight_s1,
	output logic                              last_in_flight_s2,
	output logic                              job_push,
	output csim_pkg::job_t                    job
);
	import csim_pkg::*;

	logic                          valid_s1, last_s1;
	logic signed [SAMPLE_BITS-1:0] a_s1, b_s1;
	logic                          valid_s2, last_s2;
	logic signed [PROD_W-1:0]      pab_s2, paa_s2, pbb_s2;
	logic [SUM_W-1:0]              dot_q, na_q, nb_q;
	logic [CNT_W-1:0]              cnt_q;
	logic                          ovf_q;

	logic                          room;
	logic [SUM_W-1:0]              dot_n, na_n, nb_n;
	logic                          ovf_n;

	assign last_in_flight_s1 = valid_s1 & last_s1;
	assign last_in_flight_s2 = valid_s2 & last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= take;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			a_s1    <= sample_a[SAMPLE_BITS-1:0];
			b_s1    <= sample_b[SAMPLE_BITS-1:0];
			last_s1 <= last_item;
		end
		if (valid_s1) begin
			pab_s2  <= a_s1 * b_s1;
			paa_s2  <= a_s1 * a_s1;
			pbb_s2  <= b_s1 * b_s1;
			last_s2 <= last_s1;
		end
	end

	// pairs past the length limit are dropped and only flagged
	always_comb begin
		room  = (cnt_q < CNT_W'(MAX_LEN));
		dot_n = dot_q;
		na_n  = na_q;
		nb_n  = nb_q;
		ovf_n = ovf_q | ~room;
		if (room) begin
			dot_n = dot_q + SUM_W'(pab_s2);
			na_n  = na_q + SUM_W'(paa_s2);
			nb_n  = nb_q + SUM_W'(pbb_s2);
		end
	end

	assign job_push   = valid_s2 & last_s2;
	assign job.dot    = dot_n;
	assign job.norm_a = na_n;
	assign job.norm_b = nb_n;
	assign job.inval  = ovf_n | (na_n == '0) | (nb_n == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q <= '0;
			na_q  <= '0;
			nb_q  <= '0;
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (valid_s2) begin
			if (last_s2) begin
				dot_q <= '0;
				na_q  <= '0;
				nb_q  <= '0;
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				dot_q <= dot_n;
				na_q  <= na_n;
				nb_q  <= nb_n;
				ovf_q <= ovf_n;
				if (room)
					cnt_q <= cnt_q + 1'b1;
			end
		end
	end

endmodule

### sv/csim_jobq.sv
module csim_jobq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  logic                        pop,
	input  csim_pkg::job_t              wr_job,
	output csim_pkg::job_t              rd_job,
	output logic                        nonempty,
	output logic [csim_pkg::QCNT_W-1:0] count
);
	import csim_pkg::*;

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QCNT_W-1:0] cnt_q;

	assign rd_job   = mem_q[rp_q];
	assign nonempty = (cnt_q != '0);
	assign count    = cnt_q;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= (wp_q == QPTR_W'(QDEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (pop)
				rp_q <= (rp_q == QPTR_W'(QDEPTH - 1)) ? '0 : rp_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (!push && pop)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

### sv/csim_back.sv
module csim_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    job_valid,
	input  csim_pkg::job_t          job,
	output logic                    job_take,
	input  logic signed [15:0]      threshold,
	input  logic                    pop,
	output logic                    empty,
	output logic signed [15:0]      similarity,
	output logic                    above_threshold,
	output logic                    invalid
);
	import csim_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MULP,
		ST_MULX,
		ST_DIV,
		ST_SQRT,
		ST_FIN
	} state_t;

	state_t            state_q;
	logic [SUM_W-1:0]  na_q, nb_q, mag_q;
	logic              neg_q, inval_q;
	logic [1:0]        k_q;
	logic [WIDE_W-1:0] acc_q, p_q;
	logic [WIDE_W:0]   rem_q;
	logic [QUO_W-1:0]  quo_q;
	logic [4:0]        step_q;
	logic [31:0]       n_q;
	logic [19:0]       srem_q;
	logic [15:0]       root_q;
	logic              res_valid_q;
	logic signed [SIM_W-1:0] sim_q;
	logic              above_q, inval_res_q;

	logic [SUM_W-1:0]  op_x, op_y;
	logic [LIMB_W-1:0] limb_x, limb_y;
	logic [SUM_W-1:0]  part;
	logic [WIDE_W-1:0] part_sh, acc_n;
	logic              ge;
	logic [WIDE_W:0]   diff;
	logic [19:0]       srem2, trial;
	logic [SIM_W-2:0]  m;
	logic signed [SIM_W-1:0] s;
	logic              res_free;

	assign empty           = ~res_valid_q;
	assign similarity      = sim_q;
	assign above_threshold = above_q;
	assign invalid         = inval_res_q;
	assign res_free        = ~res_valid_q | pop;
	assign job_take        = (state_q == ST_IDLE) & job_valid;

	// 60x60 multiply as four 30x30 partial products
	always_comb begin
		op_x   = (state_q == ST_MULP) ? na_q : mag_q;
		op_y   = (state_q == ST_MULP) ? nb_q : mag_q;
		limb_x = k_q[0] ? op_x[SUM_W-1:LIMB_W] : op_x[LIMB_W-1:0];
		limb_y = k_q[1] ? op_y[SUM_W-1:LIMB_W] : op_y[LIMB_W-1:0];
		part   = limb_x * limb_y;
		case (k_q)
			2'd0:    part_sh = WIDE_W'(part);
			2'd3:    part_sh = WIDE_W'(part) << (2 * LIMB_W);
			default: part_sh = WIDE_W'(part) << LIMB_W;
		endcase
		acc_n = acc_q + part_sh;
	end

	// restoring division of mag^2 * 2^30 by na*nb, one quotient bit a cycle
	always_comb begin
		ge   = (rem_q >= {1'b0, p_q});
		diff = ge ? rem_q - {1'b0, p_q} : rem_q;
	end

	// integer square root, one root bit a cycle
	always_comb begin
		srem2 = {srem_q[17:0], n_q[31:30]};
		trial = {2'b00, root_q, 2'b01};
	end

	always_comb begin
		m = (root_q > 16'(SIM_MAX)) ? SIM_MAX : root_q[SIM_W-2:0];
		s = neg_q ? -$signed({1'b0, m}) : $signed({1'b0, m});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			na_q        <= '0;
			nb_q        <= '0;
			mag_q       <= '0;
			neg_q       <= 1'b0;
			inval_q     <= 1'b0;
			k_q         <= '0;
			acc_q       <= '0;
			p_q         <= '0;
			rem_q       <= '0;
			quo_q       <= '0;
			step_q      <= '0;
			n_q         <= '0;
			srem_q      <= '0;
			root_q      <= '0;
			res_valid_q <= 1'b0;
			sim_q       <= '0;
			above_q     <= 1'b0;
			inval_res_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && res_free)
				res_valid_q <= 1'b1;
			else if (pop)
				res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						na_q    <= job.norm_a;
						nb_q    <= job.norm_b;
						neg_q   <= job.dot[SUM_W-1];
						mag_q   <= job.dot[SUM_W-1] ? -job.dot : job.dot;
						inval_q <= job.inval;
						acc_q   <= '0;
						k_q     <= '0;
						state_q <= job.inval ? ST_FIN : ST_MULP;
					end
				end
				ST_MULP: begin
					k_q <= k_q + 1'b1;
					if (k_q == 2'd3) begin
						p_q     <= acc_n;
						acc_q   <= '0;
						state_q <= ST_MULX;
					end else begin
						acc_q <= acc_n;
					end
				end
				ST_MULX: begin
					k_q <= k_q + 1'b1;
					if (k_q == 2'd3) begin
						rem_q   <= {1'b0, acc_n};
						quo_q   <= '0;
						step_q  <= '0;
						state_q <= ST_DIV;
					end else begin
						acc_q <= acc_n;
					end
				end
				ST_DIV: begin
					quo_q <= {quo_q[QUO_W-2:0], ge};
					rem_q <= {diff[WIDE_W-1:0], 1'b0};
					if (step_q == 5'(QUO_W - 1)) begin
						n_q     <= {1'b0, quo_q[QUO_W-2:0], ge};
						srem_q  <= '0;
						root_q  <= '0;
						step_q  <= '0;
						state_q <= ST_SQRT;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_SQRT: begin
					n_q    <= {n_q[29:0], 2'b00};
					step_q <= step_q + 1'b1;
					if (srem2 >= trial) begin
						srem_q <= srem2 - trial;
						root_q <= {root_q[14:0], 1'b1};
					end else begin
						srem_q <= srem2;
						root_q <= {root_q[14:0], 1'b0};
					end
					if (step_q == 5'd15)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (res_free) begin
						if (inval_q) begin
							sim_q       <= '0;
							above_q     <= 1'b0;
							inval_res_q <= 1'b1;
						end else begin
							sim_q       <= s;
							above_q     <= (s > threshold);
							inval_res_q <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### sv/cosine_similarity_stream.sv
// channel   direction  request             payload
// input     in         push & !full        sample_a, sample_b, last_item
// result    out        pop & !empty        similarity, above_threshold, invalid
// config    in         psel&penable&pwrite similarity_threshold at byte 0
//
// one element pair is accepted every cycle unless full is high; the front
// multiplies and sums in a three-stage pipe. a vector end enters a two-entry
// job queue; the back then runs 2x4 multiply, 31 divide and 16 root steps.
// full rises while the job queue plus vector ends still in the pipe fill it.
// reset clears all sums, the queue and the result register.
module cosine_similarity_stream (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic signed [23:0]  sample_a,
	input  logic signed [23:0]  sample_b,
	input  logic                last_item,
	output logic                empty,
	input  logic                pop,
	output logic signed [15:0]  similarity,
	output logic                above_threshold,
	output logic                invalid,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [csim_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import csim_pkg::*;

	logic signed [SIM_W-1:0] thr_q;
	logic                    take, lf_s1, lf_s2;
	job_t                    job_in, job_out;
	logic                    job_push, job_pop, job_nonempty;
	logic [QCNT_W-1:0]       job_count;
	logic [QCNT_W:0]         reserved;

	assign pready = 1'b1;
	assign prdata = {16'h0000, thr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			thr_q <= THR_RESET;
		else if (psel && penable && pwrite && paddr[2] == REG_THRESHOLD)
			thr_q <= pwdata[15:0];
	end

	// every vector end accepted but not yet taken by the back holds a queue slot
	assign reserved = (QCNT_W+1)'(job_count) + (QCNT_W+1)'(lf_s1)
			+ (QCNT_W+1)'(lf_s2);
	assign full     = (reserved >= (QCNT_W+1)'(QDEPTH));
	assign take     = push & ~full;

	csim_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.take              (take),
		.sample_a          (sample_a),
		.sample_b          (sample_b),
		.last_item         (last_item),
		.last_in_flight_s1 (lf_s1),
		.last_in_flight_s2 (lf_s2),
		.job_push          (job_push),
		.job               (job_in)
	);

	csim_jobq u_jobq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.pop      (job_pop),
		.wr_job   (job_in),
		.rd_job   (job_out),
		.nonempty (job_nonempty),
		.count    (job_count)
	);

	csim_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.job_valid       (job_nonempty),
		.job             (job_out),
		.job_take        (job_pop),
		.threshold       (thr_q),
		.pop             (pop),
		.empty           (empty),
		.similarity      (similarity),
		.above_threshold (above_threshold),
		.invalid         (invalid)
	);

endmodule

### sv/csim_checker.sv
module csim_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               empty,
	input logic               pop,
	input logic signed [15:0] similarity,
	input logic               above_threshold,
	input logic               invalid
);

	a_inval_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && invalid) |-> (similarity == 16'sd0 && !above_threshold))
		else $error("invalid result carries a value");

	a_above_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && above_threshold) |-> !invalid)
		else $error("match flag on invalid result");

	a_no_min: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> similarity != 16'sh8000)
		else $error("similarity not saturated");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(similarity) && $stable(invalid)))
		else $error("waiting result changed");

endmodule

bind cosine_similarity_stream csim_checker u_csim_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.empty           (empty),
	.pop             (pop),
	.similarity      (similarity),
	.above_threshold (above_threshold),
	.invalid         (invalid)
);

### tb/tb_cosine_similarity_stream.sv
module tb_cosine_similarity_stream;
	import csim_pkg::*;

	typedef struct {
		logic signed [23:0] a;
		logic signed [23:0] b;
		logic               last;
	} pair_t;

	typedef struct {
		logic signed [15:0] sim;
		logic               above;
		logic               inval;
	} score_t;

	typedef enum int {MIX_RANDOM, MIX_SMALL, MIX_ALIGNED, MIX_OPPOSED, MIX_NEAR, MIX_ZERO_A}
		mix_e;

	localparam int LIMIT_CYCLES = 1000000;
	localparam int TAIL_CYCLES  = 100;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	logic signed [23:0] sample_a;
	logic signed [23:0] sample_b;
	logic last_item;
	logic empty;
	logic pop;
	logic signed [15:0] similarity;
	logic above_threshold;
	logic invalid;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	cosine_similarity_stream dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.sample_a(sample_a), .sample_b(sample_b), .last_item(last_item),
		.empty(empty), .pop(pop), .similarity(similarity),
		.above_threshold(above_threshold), .invalid(invalid),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	pair_t  pair_q[$];
	score_t score_q[$];

	// predictor copy of the accumulators
	logic signed [15:0] thr_model;
	logic [59:0] dot_acc;
	logic [59:0] na_acc;
	logic [59:0] nb_acc;
	int          pair_cnt;
	bit          too_long;

	int  mismatches;
	int  results_seen;
	bit  calm;
	bit  sender_hold;
	int  cycles;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// largest m <= 32767 with m*m*na*nb <= 2^30*mag*mag
	function automatic logic [15:0] q15_ratio(logic [59:0] mag, logic [59:0] na,
			logic [59:0] nb);
		logic [191:0] prod;
		logic [191:0] rhs;
		logic [191:0] lhs;
		int lo;
		int hi;
		int mid;
		prod = 192'(na) * 192'(nb);
		rhs = (192'(mag) * 192'(mag)) << 30;
		lo = 0;
		hi = 32767;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			lhs = prod * 192'(mid * mid);
			if (lhs <= rhs)
				lo = mid;
			else
				hi = mid - 1;
		end
		return 16'(lo);
	endfunction

	task automatic accumulate(pair_t p);
		logic signed [59:0] xa;
		logic signed [59:0] xb;
		logic [59:0] mag;
		logic [15:0] m;
		logic signed [15:0] s;
		score_t r;
		xa = 60'(p.a);
		xb = 60'(p.b);
		if (pair_cnt >= MAX_LEN) begin
			too_long = 1'b1;
		end else begin
			dot_acc = dot_acc + 60'(xa * xb);
			na_acc = na_acc + 60'(xa * xa);
			nb_acc = nb_acc + 60'(xb * xb);
			pair_cnt++;
		end
		if (p.last) begin
			r.sim = '0;
			r.above = 1'b0;
			r.inval = 1'b0;
			if (too_long || na_acc == 0 || nb_acc == 0) begin
				r.inval = 1'b1;
			end else begin
				mag = dot_acc[59] ? -dot_acc : dot_acc;
				m = q15_ratio(mag, na_acc, nb_acc);
				s = dot_acc[59] ? -$signed(m) : $signed(m);
				r.sim = s;
				r.above = (s > thr_model);
			end
			score_q.insert(score_q.size(), r);
			dot_acc = '0;
			na_acc = '0;
			nb_acc = '0;
			pair_cnt = 0;
			too_long = 1'b0;
		end
	endtask

	// request driver
	int send_gap;
	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
			send_gap = 0;
		end else begin
			if (push && !full)
				accumulate(pair_q.pop_front());
			if (send_gap > 0) begin
				send_gap--;
				push <= 1'b0;
			end else if (sender_hold || pair_q.size() == 0) begin
				push <= 1'b0;
			end else if (!calm && $urandom_range(0, 15) == 0) begin
				send_gap = $urandom_range(0, 3);
				push <= 1'b0;
			end else begin
				push <= 1'b1;
				sample_a <= pair_q[0].a;
				sample_b <= pair_q[0].b;
				last_item <= pair_q[0].last;
			end
		end
	end

	// long receiver hold so the job queue fills and full backs up the input
	int long_left;
	bit long_done;
	bit recv_hold;
	always @(posedge clk) begin
		if (!arst_n) begin
			long_left = 0;
			long_done = 0;
			recv_hold <= 1'b0;
		end else if (long_left > 0) begin
			long_left--;
			recv_hold <= (long_left > 0);
		end else if (!long_done && results_seen >= 30) begin
			long_done = 1;
			long_left = 600;
			recv_hold <= 1'b1;
		end
	end

	// result monitor
	int recv_gap;
	always @(posedge clk) begin
		score_t e;
		if (!arst_n) begin
			pop <= 1'b0;
			recv_gap = 0;
		end else begin
			if (pop && !empty) begin
				results_seen++;
				if (score_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result sim=%0d above=%0b invalid=%0b",
							similarity, above_threshold, invalid);
				end else begin
					e = score_q.pop_front();
					if (e.sim !== similarity || e.above !== above_threshold ||
							e.inval !== invalid) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch exp sim=%0d above=%0b invalid=%0b, got sim=%0d above=%0b invalid=%0b",
								e.sim, e.above, e.inval, similarity, above_threshold,
								invalid);
					end
				end
			end
			if (recv_hold) begin
				pop <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				pop <= 1'b0;
			end else if (!calm && $urandom_range(0, 11) == 0) begin
				recv_gap = $urandom_range(0, 3);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic add_pair(int a, int b, bit last);
		pair_t p;
		p.a = 24'(a);
		p.b = 24'(b);
		p.last = last;
		pair_q.insert(pair_q.size(), p);
	endtask

	task automatic add_vector(int len, mix_e mix);
		int a;
		int b;
		for (int i = 0; i < len; i++) begin
			a = $signed(24'($urandom));
			case (mix)
				MIX_SMALL: begin
					a = $urandom_range(0, 14) - 7;
					b = $urandom_range(0, 14) - 7;
				end
				MIX_ALIGNED: b = a;
				MIX_OPPOSED: b = (a == -8388608) ? 8388607 : -a;
				MIX_NEAR: b = $signed(24'(a + $urandom_range(0, 2000) - 1000));
				MIX_ZERO_A: begin
					a = 0;
					b = $signed(24'($urandom));
				end
				default: b = $signed(24'($urandom));
			endcase
			add_pair(a, b, i == len - 1);
		end
	endtask

	task automatic drain();
		wait (pair_q.size() == 0 && !push && score_q.size() == 0);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_threshold(logic signed [15:0] v);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= ADDR_W'({REG_THRESHOLD, 2'b00});
		pwdata <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		thr_model = v;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic random_phase(int items);
		int n;
		int len;
		n = 0;
		while (n < items) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
			add_vector(len, mix_e'($urandom_range(0, 5)));
			n += len;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		sample_a = '0;
		sample_b = '0;
		last_item = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		thr_model = THR_RESET;
		dot_acc = '0;
		na_acc = '0;
		nb_acc = '0;
		pair_cnt = 0;
		too_long = 0;
		mismatches = 0;
		results_seen = 0;
		calm = 0;
		sender_hold = 0;
		cycles = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, exact ratio of one, zero norms, sign flips
		add_pair(8388607, 8388607, 1);
		add_pair(-8388608, -8388608, 1);
		add_pair(8388607, -8388608, 1);
		add_pair(-8388608, 8388607, 1);
		add_pair(0, 5, 1);
		add_pair(5, 0, 1);
		add_pair(0, 0, 1);
		add_pair(1, 1, 0);
		add_pair(1, -1, 1);
		add_pair(3, 4, 0);
		add_pair(4, 3, 1);
		add_pair(100, 99, 0);
		add_pair(-100, -101, 1);
		add_pair(-1, 1, 0);
		add_pair(2, 2, 1);
		add_pair(8388607, 1, 0);
		add_pair(-8388608, 0, 0);
		add_pair(0, -8388608, 1);
		drain();

		write_threshold(16'sh8000);
		random_phase(250);
		drain();

		write_threshold(16'sh7fff);
		random_phase(250);
		drain();

		write_threshold(16'sh0000);
		random_phase(200);
		repeat (300) @(posedge clk);
		@(negedge clk);
		sender_hold = 1;
		wait (score_q.size() == 0);
		repeat (20) @(posedge clk);
		@(negedge clk);
		sender_hold = 0;
		drain();

		write_threshold(16'($urandom_range(30000, 32767)));
		random_phase(150);
		drain();

		write_threshold(16'($urandom));
		calm = 1;
		random_phase(200);
		drain();

		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
